// ===== rtl/core/esr_pkg.sv =====
// Shared constants, command types and sizes for the event subscription router.
`timescale 1ns / 1ps

package esr_pkg;

    // Table geometry
    localparam int NUM_SLOTS     = 16;
    localparam int SUBS_PER_SLOT = 8;

    // Field widths fixed by the interface
    localparam int ID_W    = 16;
    localparam int MASK_W  = 16;
    localparam int COUNT_W = 5;
    localparam int REQ_W   = 2;
    localparam int HSLOT_W = 4;

    // Derived widths
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int COL_W  = (SUBS_PER_SLOT > 1) ? $clog2(SUBS_PER_SLOT) : 1;
    localparam int CNT_W  = $clog2(SUBS_PER_SLOT + 1);
    localparam int EXT_W  = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SUBS_PER_SLOT - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SUBS_PER_SLOT);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Request codes on the input port
    localparam logic [REQ_W-1:0] REQ_POST      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUBSCRIBE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REGISTER  = 2'd3;

    // Classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_POST,
        OP_SUB,
        OP_SUB_BAD,
        OP_CLEAR,
        OP_REG
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   event_id;
        logic [ID_W-1:0]   handle_id;
        logic              active;
    } cmd_t;

endpackage

// ===== rtl/core/esr_front.sv =====
// Front end: accept requests, classify them and register the command.
`timescale 1ns / 1ps

module esr_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [esr_pkg::REQ_W-1:0]        req_type,
    input  logic [esr_pkg::HSLOT_W-1:0]      handle_slot,
    input  logic [esr_pkg::ID_W-1:0]         event_id,
    input  logic [esr_pkg::ID_W-1:0]         handle_id,
    input  logic                             slot_active,
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output esr_pkg::cmd_t                    cmd
);

    logic          valid_reg;
    logic          valid_next;
    esr_pkg::cmd_t cmd_reg;
    esr_pkg::cmd_t cmd_next;
    logic          in_range;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Classify the incoming request
    always_comb
    begin
        in_range           = (32'(handle_slot) < esr_pkg::NUM_SLOTS);
        cmd_next.slot      = esr_pkg::SLOT_W'(32'(handle_slot));
        cmd_next.event_id  = event_id;
        cmd_next.handle_id = handle_id;
        cmd_next.active    = slot_active;
        cmd_next.op        = esr_pkg::OP_NOP;
        if (req_type == esr_pkg::REQ_POST)
        begin
            cmd_next.op = esr_pkg::OP_POST;
        end
        else if (in_range)
        begin
            case (req_type)
                esr_pkg::REQ_SUBSCRIBE:
                begin
                    if (event_id == '0)
                        cmd_next.op = esr_pkg::OP_SUB_BAD;
                    else
                        cmd_next.op = esr_pkg::OP_SUB;
                end
                esr_pkg::REQ_CLEAR:    cmd_next.op = esr_pkg::OP_CLEAR;
                esr_pkg::REQ_REGISTER: cmd_next.op = esr_pkg::OP_REG;
                default:               cmd_next.op = esr_pkg::OP_NOP;
            endcase
        end
    end

    // Hold the stage until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (cmd_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cmd_reg <= cmd_next;
    end

endmodule

// ===== rtl/core/esr_queue.sv =====
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module esr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  esr_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output esr_pkg::cmd_t out_cmd
);

    esr_pkg::cmd_t                     entry_reg [esr_pkg::QUEUE_DEPTH];
    logic [esr_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [esr_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [esr_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [esr_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [esr_pkg::QFILL_W-1:0]       fill_reg;
    logic [esr_pkg::QFILL_W-1:0]       fill_next;
    logic                              push;
    logic                              pop;

    assign in_ready  = (fill_reg != esr_pkg::QFILL_W'(esr_pkg::QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

// ===== rtl/core/esr_back.sv =====
// Back end: subscription table, column scan for posts and the result register.
`timescale 1ns / 1ps

module esr_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  esr_pkg::cmd_t                  cmd,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [esr_pkg::MASK_W-1:0]     dest_mask,
    output logic [esr_pkg::COUNT_W-1:0]    dest_count,
    output logic                           status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_EMIT
    } state_t;

    typedef logic [esr_pkg::NUM_SLOTS-1:0][esr_pkg::ID_W-1:0] row_t;

    state_t                          state_reg;
    state_t                          state_next;

    // Slot table in flip-flops
    logic [esr_pkg::ID_W-1:0]        ids_reg  [esr_pkg::NUM_SLOTS];
    logic [esr_pkg::ID_W-1:0]        ids_next [esr_pkg::NUM_SLOTS];
    logic [esr_pkg::NUM_SLOTS-1:0]   en_reg;
    logic [esr_pkg::NUM_SLOTS-1:0]   en_next;
    logic [esr_pkg::CNT_W-1:0]       cnt_reg  [esr_pkg::NUM_SLOTS];
    logic [esr_pkg::CNT_W-1:0]       cnt_next [esr_pkg::NUM_SLOTS];

    // Subscription memory, one row per list column, one lane per slot
    row_t                            col_mem [esr_pkg::SUBS_PER_SLOT];
    row_t                            row_rd_reg;
    logic                            rd_en;
    logic                            wr_en;
    logic [esr_pkg::COL_W-1:0]       wr_col;
    logic [esr_pkg::SLOT_W-1:0]      wr_slot;
    logic [esr_pkg::ID_W-1:0]        wr_data;

    // Scan state
    logic [esr_pkg::COL_W-1:0]       rd_col_reg;
    logic [esr_pkg::COL_W-1:0]       rd_col_next;
    logic                            cmp_valid_reg;
    logic                            cmp_valid_next;
    logic [esr_pkg::COL_W-1:0]       cmp_col_reg;
    logic [esr_pkg::COL_W-1:0]       cmp_col_next;
    logic [esr_pkg::NUM_SLOTS-1:0]   hit_reg;
    logic [esr_pkg::NUM_SLOTS-1:0]   hit_next;
    logic [esr_pkg::NUM_SLOTS-1:0]   match_vec;
    logic [esr_pkg::ID_W-1:0]        evt_reg;
    logic [esr_pkg::ID_W-1:0]        evt_next;
    logic [esr_pkg::ID_W-1:0]        hid_reg;
    logic [esr_pkg::ID_W-1:0]        hid_next;
    logic [esr_pkg::EXT_W-1:0]       hit_ext;

    // Result register
    logic                            res_valid_reg;
    logic                            res_valid_next;
    logic [esr_pkg::MASK_W-1:0]      res_mask_reg;
    logic [esr_pkg::MASK_W-1:0]      res_mask_next;
    logic [esr_pkg::COUNT_W-1:0]     res_count_reg;
    logic [esr_pkg::COUNT_W-1:0]     res_count_next;
    logic                            res_status_reg;
    logic                            res_status_next;
    logic                            res_free;

    assign out_valid  = res_valid_reg;
    assign dest_mask  = res_mask_reg;
    assign dest_count = res_count_reg;
    assign status     = res_status_reg;
    assign res_free   = !res_valid_reg || out_ready;
    assign hit_ext    = esr_pkg::EXT_W'(hit_reg);

    // Compare one column across every slot
    always_comb
    begin
        for (int s = 0; s < esr_pkg::NUM_SLOTS; s++)
        begin
            match_vec[s] = en_reg[s]
                        && (ids_reg[s] != hid_reg)
                        && (esr_pkg::CNT_W'(cmp_col_reg) < cnt_reg[s])
                        && (row_rd_reg[s] == evt_reg);
        end
    end

    // Sequence requests
    always_comb
    begin
        state_next      = state_reg;
        ids_next        = ids_reg;
        en_next         = en_reg;
        cnt_next        = cnt_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_col          = cnt_reg[cmd.slot][esr_pkg::COL_W-1:0];
        wr_slot         = cmd.slot;
        wr_data         = cmd.event_id;
        rd_col_next     = rd_col_reg;
        cmp_valid_next  = 1'b0;
        cmp_col_next    = cmp_col_reg;
        hit_next        = cmp_valid_reg ? (hit_reg | match_vec) : hit_reg;
        evt_next        = evt_reg;
        hid_next        = hid_reg;
        res_valid_next  = res_valid_reg && !out_ready;
        res_mask_next   = res_mask_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        cmd_ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = res_free;
                if (cmd_valid && res_free)
                begin
                    res_mask_next   = '0;
                    res_count_next  = '0;
                    res_status_next = 1'b0;
                    case (cmd.op)
                        esr_pkg::OP_POST:
                        begin
                            evt_next    = cmd.event_id;
                            hid_next    = cmd.handle_id;
                            rd_col_next = '0;
                            hit_next    = '0;
                            state_next  = S_SCAN;
                        end
                        esr_pkg::OP_SUB:
                        begin
                            res_valid_next = 1'b1;
                            if (cnt_reg[cmd.slot] >= esr_pkg::CNT_FULL)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                wr_en              = 1'b1;
                                cnt_next[cmd.slot] = cnt_reg[cmd.slot] + 1'b1;
                            end
                        end
                        esr_pkg::OP_SUB_BAD:
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = 1'b1;
                        end
                        esr_pkg::OP_CLEAR:
                        begin
                            res_valid_next     = 1'b1;
                            cnt_next[cmd.slot] = '0;
                        end
                        esr_pkg::OP_REG:
                        begin
                            res_valid_next     = 1'b1;
                            ids_next[cmd.slot] = cmd.handle_id;
                            en_next[cmd.slot]  = cmd.active;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                rd_en          = 1'b1;
                cmp_valid_next = 1'b1;
                cmp_col_next   = rd_col_reg;
                if (rd_col_reg == esr_pkg::COL_LAST)
                    state_next = S_FLUSH;
                else
                    rd_col_next = rd_col_reg + 1'b1;
            end
            S_FLUSH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_mask_next   = hit_ext[esr_pkg::MASK_W-1:0];
                    res_count_next  =
                        esr_pkg::COUNT_W'($countones(hit_ext[esr_pkg::MASK_W-1:0]));
                    res_status_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            en_reg        <= '0;
            for (int s = 0; s < esr_pkg::NUM_SLOTS; s++)
            begin
                ids_reg[s] <= '0;
                cnt_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            res_valid_reg <= res_valid_next;
            en_reg        <= en_next;
            ids_reg       <= ids_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Scan payload and result fields
    always_ff @(posedge clk)
    begin
        rd_col_reg     <= rd_col_next;
        cmp_col_reg    <= cmp_col_next;
        hit_reg        <= hit_next;
        evt_reg        <= evt_next;
        hid_reg        <= hid_next;
        res_mask_reg   <= res_mask_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
    end

    // Subscription memory: one lane write, one registered row read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            col_mem[wr_col][wr_slot] <= wr_data;
        if (rd_en)
            row_rd_reg <= col_mem[rd_col_reg];
    end

endmodule

// ===== rtl/core/event_subscription_router_core.sv =====
// Top level of the event subscription router: front end, command queue, back end.
// Subscribe, clear and register: the result passes the front register, the queue entry
// and the result register, one per cycle while the receiver is ready. Post: one column
// of every list per cycle via the memory read port; no new command until its result is out.
// Reset clears slot ids, enable flags and list fill counts at once; no clearing pass.
`timescale 1ns / 1ps

module event_subscription_router_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [esr_pkg::REQ_W-1:0]      req_type,
    input  logic [esr_pkg::HSLOT_W-1:0]    handle_slot,
    input  logic [esr_pkg::ID_W-1:0]       event_id,
    input  logic [esr_pkg::ID_W-1:0]       handle_id,
    input  logic                           slot_active,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [esr_pkg::MASK_W-1:0]     dest_mask,
    output logic [esr_pkg::COUNT_W-1:0]    dest_count,
    output logic                           status
);

    logic          front_valid;
    logic          front_ready;
    esr_pkg::cmd_t front_cmd;
    logic          back_valid;
    logic          back_ready;
    esr_pkg::cmd_t back_cmd;

    esr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .handle_slot (handle_slot),
        .event_id    (event_id),
        .handle_id   (handle_id),
        .slot_active (slot_active),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready),
        .cmd         (front_cmd)
    );

    esr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    esr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .cmd        (back_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dest_mask  (dest_mask),
        .dest_count (dest_count),
        .status     (status)
    );

endmodule

// ===== tb/sv/event_subscription_router_core_tb.sv =====
// Self-checking testbench for the event subscription router core.
`timescale 1ns / 1ps

module event_subscription_router_core_tb;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 10;
    localparam int TOTAL_REQS  = 950;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    // One predicted answer, tagged with the request that caused it
    typedef struct packed {
        logic [esr_pkg::MASK_W-1:0]  mask;
        logic [esr_pkg::COUNT_W-1:0] count;
        logic                        status;
        logic [esr_pkg::REQ_W-1:0]   req;
    } route_result_t;

    // Subscription table mirror, expected answers and request statistics
    class route_scoreboard;
        logic [esr_pkg::ID_W-1:0] slot_id [esr_pkg::NUM_SLOTS];
        bit                       slot_on [esr_pkg::NUM_SLOTS];
        logic [esr_pkg::ID_W-1:0] sub_list [esr_pkg::NUM_SLOTS][esr_pkg::SUBS_PER_SLOT];
        int                       sub_fill [esr_pkg::NUM_SLOTS];
        route_result_t            expected_routes[$];
        int                       mismatches;
        int                       n_post;
        int                       n_delivered;
        int                       widest_fanout;
        int                       n_sub;
        int                       n_refused;
        int                       n_clear;
        int                       n_reg;

        function new();
            for (int s = 0; s < esr_pkg::NUM_SLOTS; s++)
            begin
                slot_id[s]  = '0;
                slot_on[s]  = 1'b0;
                sub_fill[s] = 0;
                for (int k = 0; k < esr_pkg::SUBS_PER_SLOT; k++)
                    sub_list[s][k] = '0;
            end
            mismatches    = 0;
            n_post        = 0;
            n_delivered   = 0;
            widest_fanout = 0;
            n_sub         = 0;
            n_refused     = 0;
            n_clear       = 0;
            n_reg         = 0;
        endfunction

        // Work out the answer to one request and update the table mirror
        function route_result_t predict_route(logic [esr_pkg::REQ_W-1:0] req,
                                              logic [esr_pkg::HSLOT_W-1:0] slot,
                                              logic [esr_pkg::ID_W-1:0] evt,
                                              logic [esr_pkg::ID_W-1:0] hid,
                                              logic act);
            route_result_t r;
            bit            hit;
            r     = '0;
            r.req = req;
            if (req == esr_pkg::REQ_POST)
            begin
                // Compare only the valid prefix of each enabled list, skip the source
                for (int s = 0; s < esr_pkg::NUM_SLOTS; s++)
                begin
                    if (slot_on[s] && slot_id[s] != hid)
                    begin
                        hit = 1'b0;
                        for (int k = 0; k < sub_fill[s]; k++)
                            if (sub_list[s][k] == evt)
                                hit = 1'b1;
                        if (hit)
                        begin
                            if (s < esr_pkg::MASK_W)
                                r.mask[s] = 1'b1;
                            r.count = r.count + 1'b1;
                        end
                    end
                end
            end
            else if (int'(slot) < esr_pkg::NUM_SLOTS)
            begin
                case (req)
                    esr_pkg::REQ_SUBSCRIBE:
                    begin
                        if (evt == '0 || sub_fill[slot] >= esr_pkg::SUBS_PER_SLOT)
                            r.status = 1'b1;
                        else
                        begin
                            sub_list[slot][sub_fill[slot]] = evt;
                            sub_fill[slot] = sub_fill[slot] + 1;
                        end
                    end
                    esr_pkg::REQ_CLEAR:
                    begin
                        for (int k = 0; k < esr_pkg::SUBS_PER_SLOT; k++)
                            sub_list[slot][k] = '0;
                        sub_fill[slot] = 0;
                    end
                    default:
                    begin
                        slot_id[slot] = hid;
                        slot_on[slot] = act;
                    end
                endcase
            end
            return r;
        endfunction

        // Note an accepted request and queue its answer
        function void note_request(logic [esr_pkg::REQ_W-1:0] req,
                                   logic [esr_pkg::HSLOT_W-1:0] slot,
                                   logic [esr_pkg::ID_W-1:0] evt,
                                   logic [esr_pkg::ID_W-1:0] hid, logic act);
            route_result_t r;
            r = predict_route(req, slot, evt, hid, act);
            expected_routes.push_back(r);
            case (req)
                esr_pkg::REQ_POST:
                begin
                    n_post++;
                    if (r.count != 0)
                        n_delivered++;
                    if (int'(r.count) > widest_fanout)
                        widest_fanout = int'(r.count);
                end
                esr_pkg::REQ_SUBSCRIBE:
                begin
                    n_sub++;
                    if (r.status)
                        n_refused++;
                end
                esr_pkg::REQ_CLEAR:
                    n_clear++;
                default:
                    n_reg++;
            endcase
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [esr_pkg::MASK_W-1:0] mask,
                                   logic [esr_pkg::COUNT_W-1:0] count, logic status);
            route_result_t r;
            if (expected_routes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: mask %h count %0d status %0b",
                             $realtime, mask, count, status);
                return;
            end
            r = expected_routes.pop_front();
            if (mask !== r.mask || count !== r.count || status !== r.status)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] mismatch on req %0d: ", $realtime, r.req,
                             "expected mask %h count %0d status %0b, ",
                             r.mask, r.count, r.status,
                             "got mask %h count %0d status %0b", mask, count, status);
            end
        endfunction

        function int pending();
            return expected_routes.size();
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [esr_pkg::REQ_W-1:0]    req_type;
    logic [esr_pkg::HSLOT_W-1:0]  handle_slot;
    logic [esr_pkg::ID_W-1:0]     event_id;
    logic [esr_pkg::ID_W-1:0]     handle_id;
    logic                         slot_active;
    logic                         out_valid;
    logic                         out_ready;
    logic [esr_pkg::MASK_W-1:0]   dest_mask;
    logic [esr_pkg::COUNT_W-1:0]  dest_count;
    logic                         status;

    route_scoreboard              sb;
    int                           sent_count;
    int                           stall_cycles;
    bit                           no_idle;
    bit                           holdoff_start;
    bit                           hold_used;
    int                           hold_left;
    logic [esr_pkg::ID_W-1:0]     id_pool [8];
    logic [esr_pkg::ID_W-1:0]     evt_pool [12];

    event_subscription_router_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .handle_slot (handle_slot),
        .event_id    (event_id),
        .handle_id   (handle_id),
        .slot_active (slot_active),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dest_mask   (dest_mask),
        .dest_count  (dest_count),
        .status      (status)
    );

    // Free-running clock
    initial
        clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Watch both channels: note each request transfer, check each result transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(req_type, handle_slot, event_id, handle_id, slot_active);
        if (rst_n && out_valid && out_ready)
            sb.check_result(dest_mask, dest_count, status);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Receiver: random back-pressure, one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (holdoff_start && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= no_idle || ($urandom_range(0, 99) >= 14);
    end

    // Abort when nothing has moved for too long
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one request, with an optional random gap first, and hold it until taken
    task automatic send_req(input logic [esr_pkg::REQ_W-1:0] req,
                            input logic [esr_pkg::HSLOT_W-1:0] slot,
                            input logic [esr_pkg::ID_W-1:0] evt,
                            input logic [esr_pkg::ID_W-1:0] hid,
                            input logic act);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 14)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        handle_slot <= slot;
        event_id    <= evt;
        handle_id   <= hid;
        slot_active <= act;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    function automatic logic [esr_pkg::ID_W-1:0] rand_id();
        return esr_pkg::ID_W'($urandom);
    endfunction

    function automatic logic [esr_pkg::HSLOT_W-1:0] rand_slot();
        return esr_pkg::HSLOT_W'($urandom);
    endfunction

    function automatic logic [esr_pkg::REQ_W-1:0] rand_req();
        return esr_pkg::REQ_W'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom);
    endfunction

    function automatic logic [esr_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 80)
            return id_pool[$urandom_range(0, 7)];
        return rand_id();
    endfunction

    function automatic logic [esr_pkg::ID_W-1:0] pick_event();
        if ($urandom_range(0, 99) < 88)
            return evt_pool[$urandom_range(0, 11)];
        return rand_id();
    endfunction

    // One random step: mostly table traffic drawn from small pools, some noise and bursts
    task automatic send_random_item();
        int                          r;
        logic [esr_pkg::HSLOT_W-1:0] slot;
        logic [esr_pkg::ID_W-1:0]    evt;
        r    = $urandom_range(0, 199);
        slot = rand_slot();
        if (r < 2)
        begin
            // Broadcast: every slot enabled and subscribed to one event
            evt = pick_event();
            if (evt == '0)
                evt = 16'h0001;
            for (int s = 0; s < esr_pkg::NUM_SLOTS; s++)
            begin
                send_req(esr_pkg::REQ_CLEAR, esr_pkg::HSLOT_W'(s), rand_id(), rand_id(),
                         rand_bit());
                send_req(esr_pkg::REQ_REGISTER, esr_pkg::HSLOT_W'(s), rand_id(),
                         16'hA000 | esr_pkg::ID_W'(s), 1'b1);
                send_req(esr_pkg::REQ_SUBSCRIBE, esr_pkg::HSLOT_W'(s), evt, rand_id(),
                         rand_bit());
            end
            send_req(esr_pkg::REQ_POST, rand_slot(), evt, 16'h5555, rand_bit());
        end
        else if (r < 10)
        begin
            // Fill one list past its end
            for (int k = 0; k <= esr_pkg::SUBS_PER_SLOT; k++)
                send_req(esr_pkg::REQ_SUBSCRIBE, slot, pick_event() | 16'h0001, rand_id(),
                         rand_bit());
        end
        else if (r < 70)
            send_req(esr_pkg::REQ_POST, rand_slot(), pick_event(), pick_id(), rand_bit());
        else if (r < 125)
        begin
            evt = ($urandom_range(0, 99) < 5) ? '0 : pick_event();
            send_req(esr_pkg::REQ_SUBSCRIBE, slot, evt, rand_id(), rand_bit());
        end
        else if (r < 140)
            send_req(esr_pkg::REQ_CLEAR, slot, rand_id(), rand_id(), rand_bit());
        else if (r < 175)
            send_req(esr_pkg::REQ_REGISTER, slot, rand_id(), pick_id(),
                     $urandom_range(0, 99) < 80);
        else
            send_req(rand_req(), rand_slot(), rand_id(), rand_id(), rand_bit());
    endtask

    // Main sequence
    initial
    begin
        sb            = new();
        sent_count    = 0;
        stall_cycles  = 0;
        hold_used     = 1'b0;
        hold_left     = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= esr_pkg::REQ_POST;
        handle_slot   <= '0;
        event_id      <= '0;
        handle_id     <= '0;
        slot_active   <= 1'b0;
        no_idle       <= 1'b0;
        holdoff_start <= 1'b0;

        // Pools with the extremes in them, so that posts find subscribers
        id_pool[0] = 16'h0000;
        id_pool[7] = 16'hFFFF;
        for (int i = 1; i < 7; i++)
            id_pool[i] = rand_id();
        evt_pool[0] = 16'hFFFF;
        evt_pool[1] = 16'h0001;
        for (int i = 2; i < 12; i++)
            evt_pool[i] = rand_id();

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: post on an empty table
        send_req(esr_pkg::REQ_POST, 4'd0, 16'hFFFF, 16'h0000, 1'b0);
        // Register the end slots, one disabled slot in between
        send_req(esr_pkg::REQ_REGISTER, 4'd0, 16'h0000, 16'h0000, 1'b1);
        send_req(esr_pkg::REQ_REGISTER, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1);
        send_req(esr_pkg::REQ_REGISTER, 4'd5, 16'h0000, 16'h1234, 1'b0);
        // Subscribe with event zero is refused
        send_req(esr_pkg::REQ_SUBSCRIBE, 4'd0, 16'h0000, 16'hFFFF, 1'b1);
        send_req(esr_pkg::REQ_SUBSCRIBE, 4'd0, 16'hFFFF, 16'h0000, 1'b0);
        send_req(esr_pkg::REQ_SUBSCRIBE, 4'd15, 16'hFFFF, 16'h0000, 1'b0);
        send_req(esr_pkg::REQ_SUBSCRIBE, 4'd5, 16'hFFFF, 16'h0000, 1'b0);
        send_req(esr_pkg::REQ_POST, 4'd15, 16'hFFFF, 16'h5555, 1'b1);
        // Source exclusion by id
        send_req(esr_pkg::REQ_POST, 4'd0, 16'hFFFF, 16'h0000, 1'b0);
        // Event zero matches nothing, stale zero entries included
        send_req(esr_pkg::REQ_POST, 4'd0, 16'h0000, 16'h5555, 1'b0);
        // Duplicate subscribe still counts once
        send_req(esr_pkg::REQ_SUBSCRIBE, 4'd15, 16'hFFFF, 16'h0000, 1'b0);
        send_req(esr_pkg::REQ_POST, 4'd0, 16'hFFFF, 16'h5555, 1'b0);
        // Fill slot 15 and overflow it
        for (int k = 2; k < esr_pkg::SUBS_PER_SLOT; k++)
            send_req(esr_pkg::REQ_SUBSCRIBE, 4'd15, 16'h0100 + esr_pkg::ID_W'(k), 16'h0000,
                     1'b0);
        send_req(esr_pkg::REQ_SUBSCRIBE, 4'd15, 16'h0001, 16'h0000, 1'b0);
        // Clear, then two enabled slots sharing an id are both left out
        send_req(esr_pkg::REQ_CLEAR, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1);
        send_req(esr_pkg::REQ_REGISTER, 4'd1, 16'h0000, 16'h0000, 1'b1);
        send_req(esr_pkg::REQ_SUBSCRIBE, 4'd1, 16'hFFFF, 16'h0000, 1'b0);
        send_req(esr_pkg::REQ_POST, 4'd0, 16'hFFFF, 16'h0000, 1'b0);
        send_req(esr_pkg::REQ_POST, 4'd0, 16'hFFFF, 16'h7777, 1'b0);

        // Random traffic, then pause until the pipeline has drained
        while (sent_count < 330)
            send_random_item();
        wait_for_results();

        // Stretch with no idling on either side
        no_idle <= 1'b1;
        while (sent_count < 480)
            send_random_item();
        no_idle <= 1'b0;

        // Receiver holds off while requests keep coming
        holdoff_start <= 1'b1;
        while (sent_count < 530)
            send_random_item();

        while (sent_count < TOTAL_REQS)
            send_random_item();

        // Drain, then idle for a tail so that stray results show up
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests: ", sent_count,
                 "%0d posts (%0d delivered, widest fan-out %0d), ",
                 sb.n_post, sb.n_delivered, sb.widest_fanout,
                 "%0d subscribes (%0d refused),", sb.n_sub, sb.n_refused);
        $display("  %0d clears, %0d registers; %0d mismatches",
                 sb.n_clear, sb.n_reg, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== event_subscription_router_core.f =====
rtl/core/esr_pkg.sv
rtl/core/esr_front.sv
rtl/core/esr_queue.sv
rtl/core/esr_back.sv
rtl/core/event_subscription_router_core.sv
tb/sv/event_subscription_router_core_tb.sv
